// ===== hw/rtl/rpu_pkg.sv =====
// Shared constants, codes, types and width helpers of the row predictor undo block.
package rpu_pkg;

	// Storage defaults for the top-level parameters.
	localparam int MAX_ROW_BYTES_DEF   = 8192;
	localparam int MAX_PIXEL_BYTES_DEF = 32;

	// Fixed widths that follow from the register widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 14;
	localparam int CB_W       = 10;  // color_count * component_bits, up to 31 * 31
	localparam int PROD_W     = 24;  // row_columns * CB, up to 16383 * 961
	localparam int POS_W      = 21;  // row length in bytes and row position

	localparam int BITS_TIFF  = 8;   // the only component depth TIFF mode supports
	localparam int ROUND_UP   = 7;   // rounds bits up to whole bytes

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLORS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BITS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd3;

	// Predictor modes; the unused code behaves as pass-through.
	localparam logic [1:0] MODE_PASS = 2'd0;
	localparam logic [1:0] MODE_TIFF = 2'd1;
	localparam logic [1:0] MODE_PNG  = 2'd2;

	// Result status codes.
	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_DEPTH = 2'd1;
	localparam logic [1:0] STATUS_LONG  = 2'd2;

	// PNG filter types.
	localparam logic [7:0] FILT_NONE  = 8'd0;
	localparam logic [7:0] FILT_SUB   = 8'd1;
	localparam logic [7:0] FILT_UP    = 8'd2;
	localparam logic [7:0] FILT_AVG   = 8'd3;
	localparam logic [7:0] FILT_PAETH = 8'd4;

	// Configuration sequencer states.
	typedef enum logic [2:0] {
		CFG_IDLE,
		CFG_MUL1,
		CFG_MUL2,
		CFG_LEN,
		CFG_MOD
	} cfg_state_t;

	// Derived configuration handed from the configuration unit to the datapath.
	typedef struct packed {
		logic [1:0]       mode;
		logic             tiff_ok;
		logic [POS_W-1:0] row_len;
		logic             busy;
		logic             slot_load;
	} cfg_t;

	// Bits needed to hold a pixel size of up to n bytes.
	function automatic int bpp_w(input int n);
		return $clog2(n + 1);
	endfunction

	// Bits needed to index n pixel history entries.
	function automatic int slot_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

endpackage

// ===== hw/rtl/row_predictor_undo_core.sv =====
// Top level of the row predictor undo block: row tracking, line store and result stage.
//
// Undoes PDF stream predictors one byte per beat. Mode 0 (and the unused
// mode 3) passes bytes through, mode 1 undoes TIFF horizontal differencing
// for 8-bit components, mode 2 undoes PNG per-row filters, where the first
// byte of each row is a filter type that yields no result beat. Every result
// carries the raw byte, a row-end flag and a status. In steady state, with no
// output stall, the block takes one input beat per cycle. A result passes the
// execute stage, which reads the line store, and then the output register.
// The rate is set by the left-neighbor loop, which closes in the execute
// stage through one history read and one adder. A read of the store entry
// that the leaving beat writes in the same cycle is forwarded; in PNG mode the
// filter type byte between rows already keeps the last write of a row ahead
// of the reads of the next row. After the last configuration write the input
// is stalled while two multiply steps derive the pixel and row sizes and a
// 21-step serial modulo realigns the pixel slot to the current row position.
// The line store needs no clearing pass: bytes above the first row of a stream
// read zero through the previous-row flag. At stream end the consumer keeps a
// trailing partial row in TIFF mode and drops it in PNG mode.
module row_predictor_undo_core #(
	parameter int MAX_ROW_BYTES   = rpu_pkg::MAX_ROW_BYTES_DEF,
	parameter int MAX_PIXEL_BYTES = rpu_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rpu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpu_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_byte,
	input  logic                           stream_start,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_byte,
	output logic [7:0]                     raw_byte,
	output logic                           row_end,
	output logic [1:0]                     status
);
	import rpu_pkg::*;

	localparam int BPW = bpp_w(MAX_PIXEL_BYTES);
	localparam int SW  = slot_w(MAX_PIXEL_BYTES);
	localparam int AW  = $clog2(MAX_ROW_BYTES);
	localparam logic [POS_W-1:0] MAX_ROW_L = POS_W'(MAX_ROW_BYTES);

	// Configuration unit.
	cfg_t            cfg_s;
	logic [BPW-1:0]  bpp;
	logic [SW-1:0]   slot_fix;

	// Row tracking state.
	logic [POS_W-1:0] pos_q;
	logic [SW-1:0]    slot_q;
	logic             exp_q;
	logic             hp_q;
	logic [7:0]       filt_q;

	// Front-end decode of the beat being accepted.
	logic             accept, accept_data;
	logic [POS_W-1:0] k_cur, k_inc, pos_d;
	logic [SW-1:0]    slot_cur, slot_adv, slot_d;
	logic [BPW-1:0]   slot_inc;
	logic             exp_cur, hp_cur, exp_d, hp_d, row_last, produce;
	logic [7:0]       filt_d;
	logic             row_end_f;
	logic [1:0]       status_f;

	// Execute stage.
	logic             s1_valid_q;
	logic [7:0]       byte_s1, filt_s1;
	logic [1:0]       mode_s1, status_s1;
	logic             tiff_ok_s1, kge_s1, instore_s1, hp_s1, row_end_s1;
	logic [SW-1:0]    slot_s1;
	logic [AW-1:0]    addr_s1;
	logic             fwd_s1;
	logic [7:0]       fwd_data_s1;
	logic             s1_fire, out_free;

	// Pixel histories of the current row and of the row above.
	logic [7:0]       left_q   [MAX_PIXEL_BYTES];
	logic [7:0]       upleft_q [MAX_PIXEL_BYTES];

	logic [7:0]       ram_rd, up_raw, hist_a, hist_c, a_png, up_png, c_png, png_v, v_s1;
	logic             left_we, ul_we, st_we;

	// Output register.
	logic             out_valid_q;
	logic [7:0]       out_byte_q, raw_byte_q;
	logic             row_end_q;
	logic [1:0]       status_q;

	rpu_cfg #(
		.MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.row_pos  (pos_q),
		.cfg      (cfg_s),
		.bpp      (bpp),
		.slot_fix (slot_fix)
	);

	// The output register frees up when it is empty or its beat leaves now.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_fire  = s1_valid_q && out_free;
	// The execute stage holds one beat; a new one enters as the old one leaves.
	assign in_stall = cfg_s.busy || (s1_valid_q && !out_free);
	assign accept   = in_valid && !in_stall;
	assign accept_data = accept && produce;

	// Front end: apply a stream start, then work out where the beat sits in its row
	// and what the row tracking state becomes.
	always_comb begin
		k_cur    = stream_start ? '0 : pos_q;
		slot_cur = stream_start ? '0 : slot_q;
		exp_cur  = stream_start ? 1'b1 : exp_q;
		hp_cur   = stream_start ? 1'b0 : hp_q;
		k_inc    = k_cur + POS_W'(1);
		row_last = (k_inc >= cfg_s.row_len);
		slot_inc = BPW'(slot_cur) + BPW'(1);
		slot_adv = (row_last || slot_inc == bpp) ? '0 : SW'(slot_inc);

		pos_d     = k_cur;
		slot_d    = slot_cur;
		exp_d     = exp_cur;
		hp_d      = hp_cur;
		filt_d    = filt_q;
		produce   = 1'b1;
		row_end_f = 1'b0;
		status_f  = STATUS_OK;
		unique case (cfg_s.mode)
			MODE_TIFF: begin
				status_f  = cfg_s.tiff_ok ? STATUS_OK : STATUS_DEPTH;
				row_end_f = row_last;
				pos_d     = row_last ? '0 : k_inc;
				slot_d    = slot_adv;
			end
			MODE_PNG: begin
				if (exp_cur) begin
					// Filter type byte: remembered, no result.
					produce = 1'b0;
					filt_d  = in_byte;
					exp_d   = 1'b0;
					pos_d   = '0;
					slot_d  = '0;
				end else begin
					status_f  = (cfg_s.row_len > MAX_ROW_L) ? STATUS_LONG : STATUS_OK;
					row_end_f = row_last;
					pos_d     = row_last ? '0 : k_inc;
					slot_d    = slot_adv;
					if (row_last) begin
						exp_d = 1'b1;
						hp_d  = 1'b1;
					end
				end
			end
			MODE_PASS: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			slot_q <= '0;
			exp_q  <= 1'b1;
			hp_q   <= 1'b0;
			filt_q <= FILT_NONE;
		end else if (accept) begin
			pos_q  <= pos_d;
			slot_q <= slot_d;
			exp_q  <= exp_d;
			hp_q   <= hp_d;
			filt_q <= filt_d;
		end else if (cfg_s.slot_load) begin
			slot_q <= slot_fix;
		end
	end

	// The line store holds the decoded previous row. It is read as a beat enters
	// the execute stage and written when that beat leaves it.
	rpu_ram #(
		.WIDTH(8),
		.DEPTH(MAX_ROW_BYTES)
	) u_line_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(addr_s1),
		.wdata(v_s1),
		.re   (accept_data),
		.raddr(k_cur[AW-1:0]),
		.rdata(ram_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_s1     <= 1'b0;
		end else if (accept_data) begin
			s1_valid_q <= 1'b1;
			// The store returns old data when the leaving beat writes the same entry.
			fwd_s1     <= st_we && (addr_s1 == k_cur[AW-1:0]);
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_data) begin
			byte_s1     <= in_byte;
			filt_s1     <= filt_q;
			mode_s1     <= cfg_s.mode;
			status_s1   <= status_f;
			tiff_ok_s1  <= cfg_s.tiff_ok;
			kge_s1      <= (k_cur >= POS_W'(bpp));
			instore_s1  <= (k_cur < MAX_ROW_L);
			hp_s1       <= hp_cur;
			row_end_s1  <= row_end_f;
			slot_s1     <= slot_cur;
			addr_s1     <= k_cur[AW-1:0];
			fwd_data_s1 <= v_s1;
		end
	end

	// Execute stage: gather neighbors and rebuild the byte.
	always_comb begin
		hist_a = left_q[slot_s1];
		hist_c = upleft_q[slot_s1];
		up_raw = fwd_s1 ? fwd_data_s1 : ram_rd;
		a_png  = kge_s1 ? hist_a : 8'd0;
		up_png = (hp_s1 && instore_s1) ? up_raw : 8'd0;
		c_png  = (hp_s1 && kge_s1) ? hist_c : 8'd0;
	end

	rpu_filter u_filter (
		.x   (byte_s1),
		.a   (a_png),
		.up  (up_png),
		.c   (c_png),
		.filt(filt_s1),
		.v   (png_v)
	);

	always_comb begin
		v_s1    = byte_s1;
		left_we = 1'b0;
		ul_we   = 1'b0;
		st_we   = 1'b0;
		unique case (mode_s1)
			MODE_TIFF: begin
				if (tiff_ok_s1) begin
					v_s1    = kge_s1 ? byte_s1 + hist_a : byte_s1;
					left_we = s1_fire;
				end
			end
			MODE_PNG: begin
				v_s1    = png_v;
				left_we = s1_fire;
				ul_we   = s1_fire;
				st_we   = s1_fire && instore_s1;
			end
			MODE_PASS: ;
			default: ;
		endcase
	end

	// A stream start clears the histories; it wins over the older beat's update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else if (accept && stream_start) begin
			for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else begin
			if (left_we) begin
				left_q[slot_s1] <= v_s1;
			end
			if (ul_we) begin
				upleft_q[slot_s1] <= up_png;
			end
		end
	end

	// Output register parts the execute stage from the consumer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			out_byte_q <= v_s1;
			raw_byte_q <= byte_s1;
			row_end_q  <= row_end_s1;
			status_q   <= status_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign raw_byte  = raw_byte_q;
	assign row_end   = row_end_q;
	assign status    = status_q;

	// A PNG filter type byte never reaches the execute stage.
	a_type_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cfg_s.mode == MODE_PNG && exp_cur |=> !s1_valid_q)
		else $error("filter type byte produced a result");

	// The pixel slot stays inside the current pixel once the geometry is settled.
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_s.busy |-> (BPW'(slot_q) < bpp))
		else $error("pixel slot outside the pixel");

	// A beat blocked in the execute stage keeps its contents.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_fire |=> s1_valid_q && $stable(byte_s1) && $stable(slot_s1))
		else $error("execute stage lost a blocked beat");

endmodule

// ===== hw/rtl/rpu_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
module rpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read of the address written in the same cycle returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/rpu_filter.sv =====
// PNG per-row filter reconstruction of one byte from its left, up and up-left neighbors.
module rpu_filter (
	input  logic [7:0] x,
	input  logic [7:0] a,
	input  logic [7:0] up,
	input  logic [7:0] c,
	input  logic [7:0] filt,
	output logic [7:0] v
);
	import rpu_pkg::*;

	logic signed [9:0] sa, su, sc;
	logic signed [9:0] pa_s, pb_s, pc_s;
	logic [9:0]        pa, pb, pc;
	logic [8:0]        avg_sum;
	logic [7:0]        paeth, pred;

	always_comb begin
		sa = signed'({2'b00, a});
		su = signed'({2'b00, up});
		sc = signed'({2'b00, c});
		// Distances of p = a + up - c to each neighbor.
		pa_s = su - sc;
		pb_s = sa - sc;
		pc_s = sa + su - sc - sc;
		pa = pa_s[9] ? unsigned'(-pa_s) : unsigned'(pa_s);
		pb = pb_s[9] ? unsigned'(-pb_s) : unsigned'(pb_s);
		pc = pc_s[9] ? unsigned'(-pc_s) : unsigned'(pc_s);
		if (pa <= pb && pa <= pc) begin
			paeth = a;
		end else if (pb <= pc) begin
			paeth = up;
		end else begin
			paeth = c;
		end
		avg_sum = {1'b0, a} + {1'b0, up};
		unique case (filt)
			FILT_NONE:  pred = 8'd0;
			FILT_SUB:   pred = a;
			FILT_UP:    pred = up;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: pred = paeth;
			default:    pred = 8'd0;
		endcase
		v = x + pred;
	end

endmodule

// ===== hw/rtl/rpu_cfg.sv =====
// Configuration registers, derived row geometry and serial recompute of the pixel slot.
module rpu_cfg #(
	parameter int MAX_PIXEL_BYTES = rpu_pkg::MAX_PIXEL_BYTES_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [rpu_pkg::CFG_IDX_W-1:0]                 cfg_index,
	input  logic [rpu_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  logic [rpu_pkg::POS_W-1:0]                     row_pos,
	output rpu_pkg::cfg_t                                 cfg,
	output logic [rpu_pkg::bpp_w(MAX_PIXEL_BYTES)-1:0]    bpp,
	output logic [rpu_pkg::slot_w(MAX_PIXEL_BYTES)-1:0]   slot_fix
);
	import rpu_pkg::*;

	localparam int BPW   = bpp_w(MAX_PIXEL_BYTES);
	localparam int SW    = slot_w(MAX_PIXEL_BYTES);
	localparam int BIT_W = $clog2(POS_W);
	localparam int BPR_W = CB_W + 1 - 3;
	localparam logic [BPR_W-1:0] MAX_PIX_L = BPR_W'(MAX_PIXEL_BYTES);

	logic [1:0]             mode_q;
	logic [4:0]             colors_q, bits_q;
	logic [13:0]            cols_q;
	cfg_state_t             state_q, state_d;
	logic [CB_W-1:0]        cb_q;
	logic [PROD_W-1:0]      prod_q;
	logic [POS_W-1:0]       row_len_q;
	logic [BPW-1:0]         bpp_q;
	logic [BPW-1:0]         rem_q;
	logic [BIT_W-1:0]       bit_q;

	logic [4:0]             colors_eff, bits_eff;
	logic [13:0]            cols_eff;
	logic [CB_W:0]          cb_round;
	logic [BPR_W-1:0]       bpp_raw;
	logic [BPW:0]           shifted;
	logic [BPW-1:0]         rem_next;

	assign cfg_ready = 1'b1;

	always_comb begin
		colors_eff = (colors_q == 5'd0) ? 5'd1 : colors_q;
		bits_eff   = (bits_q == 5'd0) ? 5'(BITS_TIFF) : bits_q;
		cols_eff   = (cols_q == 14'd0) ? 14'd1 : cols_q;
		cb_round   = {1'b0, cb_q} + (CB_W + 1)'(ROUND_UP);
		bpp_raw    = cb_round[CB_W:3];
		// One restoring step of row_pos modulo bpp.
		shifted    = {rem_q, row_pos[bit_q]};
		rem_next   = (shifted >= {1'b0, bpp_q}) ? BPW'(shifted - {1'b0, bpp_q})
		                                        : BPW'(shifted);
	end

	// Next state: a write always restarts the sequence.
	always_comb begin
		state_d = state_q;
		if (cfg_valid) begin
			state_d = CFG_MUL1;
		end else begin
			unique case (state_q)
				CFG_IDLE: state_d = CFG_IDLE;
				CFG_MUL1: state_d = CFG_MUL2;
				CFG_MUL2: state_d = CFG_LEN;
				CFG_LEN:  state_d = CFG_MOD;
				CFG_MOD:  state_d = (bit_q == '0) ? CFG_IDLE : CFG_MOD;
				default:  state_d = CFG_IDLE;
			endcase
		end
	end

	// Outputs of the sequencer.
	always_comb begin
		cfg.mode      = mode_q;
		cfg.tiff_ok   = (bits_eff == 5'(BITS_TIFF));
		cfg.row_len   = row_len_q;
		cfg.busy      = (state_q != CFG_IDLE);
		cfg.slot_load = (state_q == CFG_MOD) && (bit_q == '0) && !cfg_valid;
		bpp           = bpp_q;
		slot_fix      = SW'(rem_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PASS;
			colors_q  <= 5'd1;
			bits_q    <= 5'(BITS_TIFF);
			cols_q    <= 14'd1;
			state_q   <= CFG_IDLE;
			cb_q      <= CB_W'(BITS_TIFF);
			prod_q    <= PROD_W'(BITS_TIFF);
			row_len_q <= POS_W'(1);
			bpp_q     <= BPW'(1);
			rem_q     <= '0;
			bit_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[1:0];
					REG_COLORS: colors_q <= cfg_data[4:0];
					REG_BITS:   bits_q   <= cfg_data[4:0];
					REG_COLS:   cols_q   <= cfg_data[13:0];
				endcase
			end
			unique case (state_q)
				CFG_MUL1: cb_q <= CB_W'(CB_W'(colors_eff) * CB_W'(bits_eff));
				CFG_MUL2: prod_q <= PROD_W'(PROD_W'(cols_eff) * PROD_W'(cb_q));
				CFG_LEN: begin
					row_len_q <= POS_W'((prod_q + PROD_W'(ROUND_UP)) >> 3);
					bpp_q     <= (bpp_raw > MAX_PIX_L) ? BPW'(MAX_PIXEL_BYTES)
					                                   : BPW'(bpp_raw);
					rem_q     <= '0;
					bit_q     <= BIT_W'(POS_W - 1);
				end
				CFG_MOD: begin
					rem_q <= rem_next;
					if (bit_q != '0) begin
						bit_q <= bit_q - BIT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of row_predictor_undo_core: directed, random and long-row streams.
module testbench;
	import rpu_pkg::*;

	// The predictor below keeps the same storage sizes as the default build of the core.
	localparam int unsigned STORE_BYTES = MAX_ROW_BYTES_DEF;
	localparam int unsigned PIXEL_SLOTS = MAX_PIXEL_BYTES_DEF;
	// The unused mode code must behave exactly like pass-through.
	localparam logic [1:0]  MODE_SPARE  = 2'd3;
	// A result passes the execute stage and the output register after its input
	// beat, so the drain pad after the last result covers a filter type byte still in flight.
	localparam int unsigned DRAIN_PAD   = 4;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned REPORT_MAX  = 10;
	// Data bytes sent at the head of a row that is far too long to send whole.
	localparam int unsigned LONG_HEAD   = 12;

	// One result beat as it leaves the core.
	typedef struct packed {
		logic [7:0] out_byte;
		logic [7:0] raw_byte;
		logic       row_end;
		logic [1:0] status;
	} result_beat_t;

	// Every input of the core starts at a known value.
	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_stall;
	logic [7:0]            in_byte      = 8'h00;
	logic                  stream_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall    = 1'b0;
	logic [7:0]            out_byte;
	logic [7:0]            raw_byte;
	logic                  row_end;
	logic [1:0]            status;

	// Shadow copy of the configuration registers, starting at their reset values.
	logic [1:0]  mode_reg   = MODE_PASS;
	logic [4:0]  colors_reg = 5'd1;
	logic [4:0]  bits_reg   = 5'd8;
	logic [13:0] cols_reg   = 14'd1;

	// Shadow copy of the reconstruction state: the previous decoded row, the last
	// pixel of the current row and of the row above, and the row tracking flags.
	logic [7:0]  above_row [STORE_BYTES];
	logic [7:0]  left_px   [PIXEL_SLOTS];
	logic [7:0]  upleft_px [PIXEL_SLOTS];
	int unsigned row_pos     = 0;
	logic        want_filter = 1'b1;
	logic [7:0]  row_filter  = FILT_NONE;
	logic        have_above  = 1'b0;

	// Beats the core still owes us, oldest first.
	result_beat_t expected_beats [$];
	result_beat_t want_beat;

	int unsigned mismatch_count = 0;
	int unsigned items_sent     = 0;
	int unsigned cycle_count    = 0;
	// Chance in percent that the sender leaves a cycle empty or the receiver stalls.
	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;

	row_predictor_undo_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_byte      (in_byte),
		.stream_start (stream_start),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.raw_byte     (raw_byte),
		.row_end      (row_end),
		.status       (status)
	);

	always #1 clk = ~clk;

	// Watchdog: a run that never drains is a failure in its own right.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// The receiver decides its stall at the falling edge, so the core sees a
	// stable value at the next rising edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Result checker. Outputs are sampled at the rising edge, before the core's
	// own updates of that edge land, and each accepted beat is matched against
	// the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_beats.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX) begin
					$display("unexpected result beat: out %h raw %h end %b status %0d",
						out_byte, raw_byte, row_end, status);
				end
			end else begin
				want_beat = expected_beats.pop_front();
				if (out_byte !== want_beat.out_byte || raw_byte !== want_beat.raw_byte ||
						row_end !== want_beat.row_end || status !== want_beat.status) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("beat mismatch: expected out %h raw %h end %b status %0d",
							want_beat.out_byte, want_beat.raw_byte, want_beat.row_end,
							want_beat.status);
						$display("               actual   out %h raw %h end %b status %0d",
							out_byte, raw_byte, row_end, status);
					end
				end
			end
		end
	end

	// Pixel and row sizes in bytes as the current registers define them. Zero
	// registers stand for one color, eight bits and one column, and a pixel is
	// never wider than the history holds.
	function automatic void row_geometry(output int unsigned bpp, output int unsigned row_len,
			output int unsigned bits);
		int unsigned colors;
		int unsigned cols;
		colors = (colors_reg != 0) ? colors_reg : 1;
		bits   = (bits_reg != 0) ? bits_reg : 8;
		cols   = (cols_reg != 0) ? cols_reg : 1;
		bpp    = (colors * bits + ROUND_UP) / 8;
		if (bpp > PIXEL_SLOTS) bpp = PIXEL_SLOTS;
		row_len = (cols * colors * bits + ROUND_UP) / 8;
	endfunction

	// PNG Paeth choice among left, above and upper-left; ties favor left, then above.
	function automatic int paeth_pick(input int a, input int b, input int c);
		int p;
		int pa;
		int pb;
		int pc;
		p  = a + b - c;
		pa = (p > a) ? p - a : a - p;
		pb = (p > b) ? p - b : b - p;
		pc = (p > c) ? p - c : c - p;
		if (pa <= pb && pa <= pc) return a;
		return (pb <= pc) ? b : c;
	endfunction

	// Advances the shadow state by one accepted input beat and queues the
	// result beat it causes. A PNG filter type byte causes none.
	task automatic predict_beat(input logic [7:0] x, input logic first);
		int unsigned  bpp;
		int unsigned  row_len;
		int unsigned  bits;
		int unsigned  k;
		int unsigned  slot;
		int unsigned  a;
		int unsigned  up;
		int unsigned  c;
		int unsigned  v;
		result_beat_t beat;
		row_geometry(bpp, row_len, bits);
		if (first) begin
			row_pos     = 0;
			want_filter = 1'b1;
			have_above  = 1'b0;
			for (int i = 0; i < PIXEL_SLOTS; i++) begin
				left_px[i]   = 8'h00;
				upleft_px[i] = 8'h00;
			end
		end
		k             = row_pos;
		slot          = k % bpp;
		v             = x;
		beat.raw_byte = x;
		beat.row_end  = 1'b0;
		beat.status   = STATUS_OK;
		if (mode_reg == MODE_TIFF) begin
			// Depths other than eight pass through flagged, but rows still count.
			if (bits != BITS_TIFF) begin
				beat.status = STATUS_DEPTH;
			end else begin
				if (k >= bpp) v = x + left_px[slot];
				left_px[slot] = v[7:0];
			end
			if (k + 1 >= row_len) begin
				beat.row_end = 1'b1;
				row_pos      = 0;
			end else begin
				row_pos = k + 1;
			end
		end else if (mode_reg == MODE_PNG) begin
			if (want_filter) begin
				row_filter  = x;
				want_filter = 1'b0;
				row_pos     = 0;
				return;
			end
			// Rows longer than the store are flagged on every data byte, and the
			// part beyond the store sees zero above and is not kept.
			if (row_len > STORE_BYTES) beat.status = STATUS_LONG;
			a  = (k >= bpp) ? left_px[slot] : 0;
			up = (have_above && k < STORE_BYTES) ? above_row[k] : 0;
			c  = (have_above && k >= bpp) ? upleft_px[slot] : 0;
			case (row_filter)
				FILT_SUB:   v = x + a;
				FILT_UP:    v = x + up;
				FILT_AVG:   v = x + ((a + up) >> 1);
				FILT_PAETH: v = x + paeth_pick(a, up, c);
				default:    v = x;
			endcase
			upleft_px[slot] = up[7:0];
			left_px[slot]   = v[7:0];
			if (k < STORE_BYTES) above_row[k] = v[7:0];
			if (k + 1 >= row_len) begin
				beat.row_end = 1'b1;
				row_pos      = 0;
				want_filter  = 1'b1;
				have_above   = 1'b1;
			end else begin
				row_pos = k + 1;
			end
		end
		beat.out_byte = v[7:0];
		expected_beats.push_back(beat);
	endtask

	// Offers one input beat, possibly after random empty cycles, and holds it
	// until the core takes it. Valid stays high afterwards until the next
	// falling edge, where the next beat or the drain task takes over.
	task automatic send_byte(input logic [7:0] value, input logic first);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		in_byte      <= value;
		stream_start <= first;
		do @(posedge clk); while (in_stall !== 1'b0);
		predict_beat(value, first);
		items_sent++;
	endtask

	// Stops offering input and waits until every predicted beat has arrived,
	// plus a short pad for a type byte that causes no beat.
	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_beats.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	// Writes one configuration register and mirrors it into the shadow copy.
	// Callers drain first, so the core is idle whenever a register changes.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (index)
			REG_MODE:   mode_reg   = data[1:0];
			REG_COLORS: colors_reg = data[4:0];
			REG_BITS:   bits_reg   = data[4:0];
			default:    cols_reg   = data[13:0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_geometry(input int unsigned colors, input int unsigned bits,
			input int unsigned cols);
		write_reg(REG_COLORS, CFG_DATA_W'(colors));
		write_reg(REG_BITS, CFG_DATA_W'(bits));
		write_reg(REG_COLS, CFG_DATA_W'(cols));
	endtask

	// One PNG row: the filter type byte, then a full row of random data.
	task automatic send_png_row(input logic [7:0] filt, input logic first);
		int unsigned bpp;
		int unsigned row_len;
		int unsigned bits;
		row_geometry(bpp, row_len, bits);
		send_byte(filt, first);
		for (int unsigned i = 0; i < row_len; i++) send_byte(8'($urandom), 1'b0);
	endtask

	// Picks a random setting, mostly small rows, sometimes zero registers, wide
	// pixels or unsupported depths. Narrow registers get junk in the unused
	// upper data bits, which the core must ignore.
	task automatic random_config;
		logic [CFG_DATA_W-1:0] word;
		int unsigned           colors;
		int unsigned           bits;
		int unsigned           pick;
		drain_results();
		word      = CFG_DATA_W'($urandom);
		word[1:0] = 2'($urandom_range(3));
		write_reg(REG_MODE, word);
		pick   = $urandom_range(9);
		colors = (pick < 7) ? $urandom_range(1, 4) : (pick == 7) ? 0 : $urandom_range(5, 31);
		word      = CFG_DATA_W'($urandom);
		word[4:0] = colors[4:0];
		write_reg(REG_COLORS, word);
		pick = $urandom_range(9);
		bits = (pick < 6) ? 8 : (pick < 8) ? $urandom_range(1, 16) :
			(pick == 8) ? 0 : $urandom_range(17, 31);
		word      = CFG_DATA_W'($urandom);
		word[4:0] = bits[4:0];
		write_reg(REG_BITS, word);
		if (colors == 0) colors = 1;
		if (bits == 0) bits = 8;
		// Wide pixels already make long rows, so they get one column at most.
		write_reg(REG_COLS, CFG_DATA_W'((colors * bits > 64) ? $urandom_range(0, 1) :
			$urandom_range(0, 8)));
	endtask

	// A stream under the current setting: mostly whole rows with valid PNG
	// filter types, sometimes an unknown type, a restart in mid-row or a
	// truncated last row. The first beat always restarts the stream, so no
	// row ever reads store entries left over from another setting.
	task automatic random_stream;
		int unsigned bpp;
		int unsigned row_len;
		int unsigned bits;
		int unsigned rows;
		int unsigned count;
		logic        first;
		logic [7:0]  filt;
		row_geometry(bpp, row_len, bits);
		rows  = $urandom_range(1, 4);
		first = 1'b1;
		for (int unsigned r = 0; r < rows; r++) begin
			if (mode_reg == MODE_PNG) begin
				filt = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(FILT_PAETH));
				send_byte(filt, first);
				first = 1'b0;
			end
			count = row_len;
			if (r == rows - 1 && $urandom_range(3) == 0) count = $urandom_range(row_len - 1);
			for (int unsigned i = 0; i < count; i++) begin
				send_byte(8'($urandom), first || ($urandom_range(49) == 0));
				first = 1'b0;
			end
		end
	endtask

	// Reset setting is pass-through; the spare mode code must act the same.
	task automatic test_pass_through;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hA5, 1'b0);
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_SPARE));
		send_byte(8'h5A, 1'b1);
		send_byte(8'hC3, 1'b0);
	endtask

	// TIFF with two 8-bit components and two columns: the first pixel of a row
	// passes, the second wraps around 256. Then a 4-bit depth, which is flagged
	// as unsupported but still marks row ends.
	task automatic test_tiff_rows;
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_TIFF));
		write_geometry(2, 8, 2);
		send_byte(8'h10, 1'b1);
		send_byte(8'hF0, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h20, 1'b0);
		send_byte(8'h01, 1'b0);
		drain_results();
		write_reg(REG_BITS, CFG_DATA_W'(4));
		send_byte(8'h7F, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h33, 1'b0);
	endtask

	// Every PNG filter on two-byte rows, with an unknown type at the end that
	// must decode as None. The first row sees zeros above.
	task automatic test_png_filters;
		logic [7:0] seq [18];
		seq = '{FILT_NONE, 8'hFF, 8'h01, FILT_SUB, 8'h80, 8'hFF, FILT_UP, 8'hFF, 8'hFF,
			FILT_AVG, 8'h01, 8'hFE, FILT_PAETH, 8'h10, 8'hF0, 8'hFF, 8'h7F, 8'h00};
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_PNG));
		write_geometry(1, 8, 2);
		for (int i = 0; i < 18; i++) send_byte(seq[i], i == 0);
	endtask

	// All size registers zero: one 8-bit byte per row. Each row then reads the
	// store entry the row before has just written.
	task automatic test_zero_registers;
		drain_results();
		write_geometry(0, 0, 0);
		send_byte(FILT_SUB, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(FILT_UP, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(FILT_PAETH, 1'b0);
		send_byte(8'h80, 1'b0);
	endtask

	// The row length shrinks while a PNG row is half done: that row must end
	// with the very next byte, and the following row uses the new length.
	task automatic test_config_mid_row;
		drain_results();
		write_geometry(1, 8, 4);
		send_byte(FILT_SUB, 1'b1);
		for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
		send_byte(FILT_UP, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		drain_results();
		write_reg(REG_COLS, CFG_DATA_W'(2));
		send_byte(8'h44, 1'b0);
		send_byte(FILT_PAETH, 1'b0);
		send_byte(8'h9C, 1'b0);
		send_byte(8'h63, 1'b0);
	endtask

	task automatic test_random_streams(input int unsigned count);
		int unsigned goal;
		goal = items_sent + count;
		while (items_sent < goal) begin
			random_config();
			random_stream();
		end
	endtask

	// Large sizes: a pixel wider than the history, clamped to it, over two whole
	// rows; the most columns; a PNG row one byte longer than the line store,
	// whose data bytes are all flagged; and a TIFF row of that length, which
	// needs no store and is never flagged. Only the head of each long row is sent.
	task automatic test_long_rows;
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_PNG));
		write_geometry(17, 16, 1);
		send_png_row(FILT_SUB, 1'b1);
		send_png_row(FILT_PAETH, 1'b0);
		drain_results();
		write_geometry(1, 1, 16383);
		send_byte(FILT_AVG, 1'b1);
		for (int unsigned i = 0; i < LONG_HEAD; i++) send_byte(8'($urandom), 1'b0);
		drain_results();
		write_geometry(1, 8, STORE_BYTES + 1);
		send_byte(FILT_SUB, 1'b1);
		for (int unsigned i = 0; i < LONG_HEAD; i++) send_byte(8'($urandom), 1'b0);
		drain_results();
		write_reg(REG_MODE, CFG_DATA_W'(MODE_TIFF));
		for (int unsigned i = 0; i < LONG_HEAD; i++) send_byte(8'($urandom), i == 0);
	endtask

	initial begin
		// Reset is held from time zero and released at a falling edge.
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// First the sender idles lightly and the receiver heavily.
		send_gap_pct   = 26;
		recv_stall_pct = 72;
		test_pass_through();
		test_tiff_rows();
		test_png_filters();
		test_zero_registers();
		test_config_mid_row();
		test_random_streams(100);

		// Then the other way round.
		send_gap_pct   = 72;
		recv_stall_pct = 26;
		test_random_streams(100);

		// Finally full rate on both sides, where the long rows run too.
		send_gap_pct   = 0;
		recv_stall_pct = 0;
		test_random_streams(60);
		test_long_rows();

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && expected_beats.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/rpu_pkg.sv
hw/rtl/rpu_ram.sv
hw/rtl/rpu_filter.sv
hw/rtl/rpu_cfg.sv
hw/rtl/row_predictor_undo_core.sv
tb/testbench.sv
